[sv/buffer_pool_frame_manager_assert.svh]
// ----------------------------------------------------------------------------
// buffer pool frame manager assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef BUFFER_POOL_FRAME_MANAGER_ASSERT_SVH
`define BUFFER_POOL_FRAME_MANAGER_ASSERT_SVH

// plain property, sampled on aclk, off during reset
`define BPFM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// overlapping implication, sampled on aclk, off during reset
`define BPFM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

[sv/bpfm_pkg.sv]
// ----------------------------------------------------------------------------
// bpfm_pkg
// types, codes and sizes shared by the buffer pool frame manager
// ----------------------------------------------------------------------------
package bpfm_pkg;

    // default pool size
    localparam int FRAMES_DEF = 16;

    // field widths
    localparam int REQ_W    = 3;
    localparam int PAGE_W   = 31;
    localparam int PIN_W    = 8;
    localparam int STATUS_W = 2;
    localparam int FRAME_W  = 4;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 48;

    localparam logic [PIN_W-1:0]  PIN_MAX   = 8'hFF;
    localparam logic [PAGE_W-1:0] NULL_PAGE = 31'h7FFF_FFFF;

    // request codes
    localparam logic [REQ_W-1:0] REQ_FETCH  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_NEW    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_UNPIN  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_FLUSH  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DELETE = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FRAME = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_PINNED   = 2'd3;

    // one entry of the frame table memory
    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic [PIN_W-1:0]  pins;
        logic              dirty;
    } frame_ent_t;

    // command to the recency list
    typedef struct packed {
        logic start;
        logic push;
    } rec_cmd_t;

    // recency list status
    typedef struct packed {
        logic busy;
        logic nonempty;
    } rec_st_t;

endpackage

[sv/bpfm_ram.sv]
// ----------------------------------------------------------------------------
// bpfm_ram
// generic single write, single read memory with registered read data
// ----------------------------------------------------------------------------
module bpfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/bpfm_recency.sv]
// ----------------------------------------------------------------------------
// bpfm_recency
// lru order of unpinned frames as a doubly linked list in two memories
// ----------------------------------------------------------------------------
module bpfm_recency import bpfm_pkg::*; #(
    parameter int FRAMES = FRAMES_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  rec_cmd_t                  cmd,
    input  logic [$clog2(FRAMES)-1:0] frame,
    output rec_st_t                   st,
    output logic [$clog2(FRAMES)-1:0] head
);

    localparam int FW = $clog2(FRAMES);
    localparam int CW = $clog2(FRAMES + 1);

    localparam logic [1:0] R_IDLE   = 2'd0;
    localparam logic [1:0] R_UNLINK = 2'd1;
    localparam logic [1:0] R_APPEND = 2'd2;

    logic [1:0]        rstate_reg, rstate_next;
    logic [FW-1:0]     frm_reg, frm_next;
    logic              push_reg, push_next;
    logic [FW-1:0]     head_reg, head_next;
    logic [FW-1:0]     tail_reg, tail_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [FRAMES-1:0] in_list_reg;
    logic              set_en, clr_en;

    logic          nx_we, pv_we;
    logic [FW-1:0] nx_waddr, pv_waddr, nx_wdata, pv_wdata;
    logic [FW-1:0] nx_rdata, pv_rdata;

    bpfm_ram #(.WIDTH(FW), .DEPTH(FRAMES)) u_next (
        .aclk(aclk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
        .raddr(frame), .rdata(nx_rdata)
    );

    bpfm_ram #(.WIDTH(FW), .DEPTH(FRAMES)) u_prev (
        .aclk(aclk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
        .raddr(frame), .rdata(pv_rdata)
    );

    // unlink and append sequencer
    always_comb begin
        rstate_next = rstate_reg;
        frm_next    = frm_reg;
        push_next   = push_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        set_en      = 1'b0;
        clr_en      = 1'b0;
        nx_we       = 1'b0;
        nx_waddr    = frm_reg;
        nx_wdata    = frm_reg;
        pv_we       = 1'b0;
        pv_waddr    = frm_reg;
        pv_wdata    = tail_reg;
        case (rstate_reg)
            R_IDLE: begin
                if (cmd.start) begin
                    frm_next  = frame;
                    push_next = cmd.push;
                    if (in_list_reg[frame]) begin
                        rstate_next = R_UNLINK;
                    end else if (cmd.push) begin
                        rstate_next = R_APPEND;
                    end
                end
            end
            R_UNLINK: begin
                // neighbors of the frame arrive from memory
                if (frm_reg != head_reg) begin
                    nx_we    = 1'b1;
                    nx_waddr = pv_rdata;
                    nx_wdata = nx_rdata;
                end else begin
                    head_next = nx_rdata;
                end
                if (frm_reg != tail_reg) begin
                    pv_we    = 1'b1;
                    pv_waddr = nx_rdata;
                    pv_wdata = pv_rdata;
                end else begin
                    tail_next = pv_rdata;
                end
                clr_en      = 1'b1;
                count_next  = count_reg - 1'b1;
                rstate_next = push_reg ? R_APPEND : R_IDLE;
            end
            R_APPEND: begin
                if (count_reg == '0) begin
                    head_next = frm_reg;
                end else begin
                    nx_we    = 1'b1;
                    nx_waddr = tail_reg;
                    nx_wdata = frm_reg;
                end
                pv_we       = 1'b1;
                pv_waddr    = frm_reg;
                pv_wdata    = tail_reg;
                tail_next   = frm_reg;
                set_en      = 1'b1;
                count_next  = count_reg + 1'b1;
                rstate_next = R_IDLE;
            end
            default: begin
                rstate_next = R_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rstate_reg  <= R_IDLE;
            count_reg   <= '0;
            in_list_reg <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
        end else begin
            rstate_reg <= rstate_next;
            count_reg  <= count_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            if (clr_en) begin
                in_list_reg[frm_reg] <= 1'b0;
            end
            if (set_en) begin
                in_list_reg[frm_reg] <= 1'b1;
            end
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        frm_reg  <= frm_next;
        push_reg <= push_next;
    end

    assign st.busy     = (rstate_reg != R_IDLE);
    assign st.nonempty = (count_reg != '0);
    assign head        = head_reg;

endmodule

[sv/buffer_pool_frame_manager.sv]
// ----------------------------------------------------------------------------
// buffer_pool_frame_manager
// page frame pool with free queue and lru replacement, one result per request
// ----------------------------------------------------------------------------
//  channel | dir | ports                      | item
//  request | in  | s_tvalid s_tready s_tdata  | req_type, page_id, dirty_flag
//  result  | out | m_tvalid m_tready m_tdata  | status, frame, write-back, flags
//
//  a result is loaded after its request is taken: a lookup through the
//  frame table's one read port over every frame, then a decide step, an
//  optional victim read and up to two list updates
//  the next item is taken in the cycle after the result is loaded, even while
//  that result waits for m_tready
//  aresetn is synchronous, active low; no clearing pass is needed after it
// ----------------------------------------------------------------------------
module buffer_pool_frame_manager import bpfm_pkg::*; #(
    parameter int FRAMES = FRAMES_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // req_type[2:0] page_id[33:3] dirty_flag[34]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // status[1:0] frame[5:2] write_back[6]
                                        // write_back_page[37:7] read_in[38]
                                        // clear_frame[39] deallocate[40]
);

    localparam int FW = $clog2(FRAMES);
    localparam int CW = $clog2(FRAMES + 1);
    localparam int SW = CW + 1;
    localparam int EW = $bits(frame_ent_t);

    localparam logic [FW-1:0] LAST_IDX = FW'(FRAMES - 1);
    localparam logic [SW-1:0] FR_SUM   = SW'(FRAMES);
    localparam logic [CW-1:0] FR_CNT   = CW'(FRAMES);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_VDATA  = 3'd3;
    localparam logic [2:0] S_RWAIT  = 3'd4;
    localparam logic [2:0] S_OUT    = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [REQ_W-1:0]    req_reg, req_next;
    logic [PAGE_W-1:0]   pid_reg, pid_next;
    logic                dflag_reg, dflag_next;
    logic [FW-1:0]       scan_idx_reg, scan_idx_next;
    logic                hit_reg, hit_next;
    logic [FW-1:0]       hf_reg, hf_next;
    logic [PIN_W-1:0]    hpins_reg, hpins_next;
    logic                hdirty_reg, hdirty_next;
    logic [FW-1:0]       vic_reg, vic_next;
    logic [FW-1:0]       fq_head_reg, fq_head_next;
    logic [CW-1:0]       fq_count_reg, fq_count_next;

    logic [STATUS_W-1:0] r_status_reg, r_status_next;
    logic [FW-1:0]       r_frame_reg, r_frame_next;
    logic                r_wb_reg, r_wb_next;
    logic [PAGE_W-1:0]   r_wbpage_reg, r_wbpage_next;
    logic                r_rdin_reg, r_rdin_next;
    logic                r_clear_reg, r_clear_next;
    logic                r_dealloc_reg, r_dealloc_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]    m_tdata_reg, m_tdata_next;

    // per frame and per queue slot flags
    logic [FRAMES-1:0]   valid_reg, written_reg, fqw_reg;
    logic                vset_en, vclr_en, fqw_en;
    logic [FW-1:0]       vclr_idx;

    // frame table memory
    logic                fr_we;
    logic [FW-1:0]       fr_waddr, fr_raddr;
    frame_ent_t          fr_wdata, fr_rdata;
    logic [EW-1:0]       fr_rdata_raw;

    // free queue memory
    logic                fq_we;
    logic [FW-1:0]       fq_waddr, fq_rdata, fq_entry;
    logic [SW-1:0]       fq_sum;
    logic [FW-1:0]       fq_slot, fq_head_inc;

    // recency list
    rec_cmd_t            rec_cmd;
    rec_st_t             rec_st;
    logic [FW-1:0]       rec_frame, rec_head;

    logic [PIN_W-1:0]    pins_dec;

    bpfm_ram #(.WIDTH(EW), .DEPTH(FRAMES)) u_frame_ram (
        .aclk(aclk), .we(fr_we), .waddr(fr_waddr), .wdata(fr_wdata),
        .raddr(fr_raddr), .rdata(fr_rdata_raw)
    );
    assign fr_rdata = frame_ent_t'(fr_rdata_raw);

    bpfm_ram #(.WIDTH(FW), .DEPTH(FRAMES)) u_free_ram (
        .aclk(aclk), .we(fq_we), .waddr(fq_waddr), .wdata(hf_reg),
        .raddr(fq_head_reg), .rdata(fq_rdata)
    );

    bpfm_recency #(.FRAMES(FRAMES)) u_recency (
        .aclk(aclk), .aresetn(aresetn), .cmd(rec_cmd), .frame(rec_frame),
        .st(rec_st), .head(rec_head)
    );

    // free queue front and tail slot; unwritten slots hold their own index
    assign fq_entry    = fqw_reg[fq_head_reg] ? fq_rdata : fq_head_reg;
    assign fq_sum      = SW'(fq_head_reg) + SW'(fq_count_reg);
    assign fq_slot     = (fq_sum >= FR_SUM) ? FW'(fq_sum - FR_SUM) : FW'(fq_sum);
    assign fq_head_inc = (fq_head_reg == LAST_IDX) ? '0 : fq_head_reg + 1'b1;
    assign fq_waddr    = fq_slot;
    assign pins_dec    = hpins_reg - 1'b1;

    assign s_tready = (state_reg == S_IDLE);

    // request sequencer
    always_comb begin
        state_next     = state_reg;
        req_next       = req_reg;
        pid_next       = pid_reg;
        dflag_next     = dflag_reg;
        scan_idx_next  = scan_idx_reg;
        hit_next       = hit_reg;
        hf_next        = hf_reg;
        hpins_next     = hpins_reg;
        hdirty_next    = hdirty_reg;
        vic_next       = vic_reg;
        fq_head_next   = fq_head_reg;
        fq_count_next  = fq_count_reg;
        r_status_next  = r_status_reg;
        r_frame_next   = r_frame_reg;
        r_wb_next      = r_wb_reg;
        r_wbpage_next  = r_wbpage_reg;
        r_rdin_next    = r_rdin_reg;
        r_clear_next   = r_clear_reg;
        r_dealloc_next = r_dealloc_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        fr_we          = 1'b0;
        fr_waddr       = hf_reg;
        fr_wdata       = '{page: pid_reg, pins: hpins_reg, dirty: hdirty_reg};
        fr_raddr       = scan_idx_reg + 1'b1;
        fq_we          = 1'b0;
        vset_en        = 1'b0;
        vclr_en        = 1'b0;
        vclr_idx       = hf_reg;
        fqw_en         = 1'b0;
        rec_cmd        = '0;
        rec_frame      = hf_reg;
        case (state_reg)
            S_IDLE: begin
                fr_raddr = '0;
                if (s_tvalid) begin
                    req_next      = s_tdata[2:0];
                    pid_next      = s_tdata[33:3];
                    dflag_next    = s_tdata[34];
                    scan_idx_next = '0;
                    hit_next      = 1'b0;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN: begin
                // first valid frame holding the page
                if (valid_reg[scan_idx_reg] && fr_rdata.page == pid_reg && !hit_reg) begin
                    hit_next    = 1'b1;
                    hf_next     = scan_idx_reg;
                    hpins_next  = fr_rdata.pins;
                    hdirty_next = fr_rdata.dirty;
                end
                if (scan_idx_reg == LAST_IDX) begin
                    state_next = S_DECIDE;
                end else begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            S_DECIDE: begin
                r_status_next  = ST_OK;
                r_frame_next   = '0;
                r_wb_next      = 1'b0;
                r_wbpage_next  = '0;
                r_rdin_next    = 1'b0;
                r_clear_next   = 1'b0;
                r_dealloc_next = 1'b0;
                state_next     = S_RWAIT;
                case (req_reg)
                    REQ_FETCH, REQ_NEW: begin
                        if (req_reg == REQ_FETCH && hit_reg) begin
                            fr_we          = 1'b1;
                            fr_wdata.pins  = (hpins_reg == PIN_MAX) ? hpins_reg
                                                                     : hpins_reg + 1'b1;
                            r_frame_next   = hf_reg;
                            rec_cmd.start  = 1'b1;
                        end else if (fq_count_reg != '0) begin
                            vic_next      = fq_entry;
                            fr_raddr      = fq_entry;
                            fq_head_next  = fq_head_inc;
                            fq_count_next = fq_count_reg - 1'b1;
                            state_next    = S_VDATA;
                        end else if (rec_st.nonempty) begin
                            vic_next      = rec_head;
                            fr_raddr      = rec_head;
                            rec_frame     = rec_head;
                            rec_cmd.start = 1'b1;
                            state_next    = S_VDATA;
                        end else begin
                            r_status_next = ST_NO_FRAME;
                            state_next    = S_OUT;
                        end
                    end
                    REQ_UNPIN: begin
                        if (!hit_reg) begin
                            r_status_next = ST_NOT_FOUND;
                        end else begin
                            fr_we          = 1'b1;
                            fr_wdata.dirty = dflag_reg;
                            r_frame_next   = hf_reg;
                            if (hpins_reg == '0) begin
                                r_status_next = ST_NOT_FOUND;
                            end else begin
                                fr_wdata.pins = pins_dec;
                                if (pins_dec == '0) begin
                                    rec_cmd.start = 1'b1;
                                    rec_cmd.push  = 1'b1;
                                end
                            end
                        end
                    end
                    REQ_FLUSH: begin
                        if (!hit_reg) begin
                            r_status_next = ST_NOT_FOUND;
                        end else begin
                            r_frame_next = hf_reg;
                            if (hdirty_reg) begin
                                r_wb_next      = 1'b1;
                                r_wbpage_next  = pid_reg;
                                fr_we          = 1'b1;
                                fr_wdata.dirty = 1'b0;
                            end
                        end
                    end
                    REQ_DELETE: begin
                        r_dealloc_next = 1'b1;
                        if (hit_reg) begin
                            r_frame_next = hf_reg;
                            if (hpins_reg != '0) begin
                                // pinned page stays, nothing freed on disk
                                r_status_next  = ST_PINNED;
                                r_dealloc_next = 1'b0;
                            end else begin
                                rec_cmd.start  = 1'b1;
                                vclr_en        = 1'b1;
                                fr_we          = 1'b1;
                                fr_wdata.page  = NULL_PAGE;
                                fr_wdata.dirty = 1'b0;
                                r_clear_next   = 1'b1;
                                if (fq_count_reg != FR_CNT) begin
                                    fq_we         = 1'b1;
                                    fqw_en        = 1'b1;
                                    fq_count_next = fq_count_reg + 1'b1;
                                end
                            end
                        end
                    end
                    default: begin
                        r_status_next = ST_NOT_FOUND;
                    end
                endcase
            end
            S_VDATA: begin
                // victim contents arrive; install the page there
                if (written_reg[vic_reg] && fr_rdata.dirty) begin
                    r_wb_next     = 1'b1;
                    r_wbpage_next = fr_rdata.page;
                end
                fr_we    = 1'b1;
                fr_waddr = vic_reg;
                fr_wdata = '{page: pid_reg, pins: PIN_W'(1), dirty: 1'b0};
                vset_en  = 1'b1;
                if (req_reg == REQ_NEW && hit_reg && hf_reg != vic_reg) begin
                    vclr_en = 1'b1;
                end
                r_frame_next = vic_reg;
                r_rdin_next  = (req_reg == REQ_FETCH);
                r_clear_next = (req_reg == REQ_NEW);
                state_next   = S_RWAIT;
            end
            S_RWAIT: begin
                if (!rec_st.busy) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'd0, r_dealloc_reg, r_clear_reg, r_rdin_reg,
                                     r_wbpage_reg, r_wb_reg, FRAME_W'(r_frame_reg),
                                     r_status_reg};
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            fq_head_reg  <= '0;
            fq_count_reg <= FR_CNT;
            valid_reg    <= '0;
            written_reg  <= '0;
            fqw_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            fq_head_reg  <= fq_head_next;
            fq_count_reg <= fq_count_next;
            if (vclr_en) begin
                valid_reg[vclr_idx] <= 1'b0;
            end
            if (vset_en) begin
                valid_reg[vic_reg]   <= 1'b1;
                written_reg[vic_reg] <= 1'b1;
            end
            if (fqw_en) begin
                fqw_reg[fq_slot] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        pid_reg       <= pid_next;
        dflag_reg     <= dflag_next;
        scan_idx_reg  <= scan_idx_next;
        hit_reg       <= hit_next;
        hf_reg        <= hf_next;
        hpins_reg     <= hpins_next;
        hdirty_reg    <= hdirty_next;
        vic_reg       <= vic_next;
        r_status_reg  <= r_status_next;
        r_frame_reg   <= r_frame_next;
        r_wb_reg      <= r_wb_next;
        r_wbpage_reg  <= r_wbpage_next;
        r_rdin_reg    <= r_rdin_next;
        r_clear_reg   <= r_clear_next;
        r_dealloc_reg <= r_dealloc_next;
        m_tdata_reg   <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[sv/bpfm_checker.sv]
// ----------------------------------------------------------------------------
// bpfm_checker
// port level checks of the buffer pool frame manager
// ----------------------------------------------------------------------------
`include "buffer_pool_frame_manager_assert.svh"

module bpfm_checker import bpfm_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    logic [STATUS_W-1:0] res_status;
    logic                res_wb, res_rdin, rd_ok, m_stall;

    // result fields and helpers
    assign res_status = m_tdata[1:0];
    assign res_wb     = m_tdata[6];
    assign res_rdin   = m_tdata[38];
    assign rd_ok      = (m_tdata[1:0] == ST_OK) && !m_tdata[39];
    assign m_stall    = m_tvalid && !m_tready;

    // a stalled result item holds
    `BPFM_ASSERT(a_out_hold, m_stall |=> m_tvalid && $stable(m_tdata), "result changed in stall")

    // one request at a time: no second item right after an accepted one
    `BPFM_ASSERT(a_one_at_a_time, s_tvalid && s_tready |=> !s_tready, "back to back accept")

    // a write-back only comes with a good status
    `BPFM_ASSERT_IMP(a_wb_ok, m_tvalid && res_wb, res_status == ST_OK, "write-back, bad status")

    // a disk read only comes with a good status and never with a frame clear
    `BPFM_ASSERT_IMP(a_read_clear, m_tvalid && res_rdin, rd_ok, "read-in with clear or bad status")

endmodule

bind buffer_pool_frame_manager bpfm_checker u_bpfm_checker (.*);

[tb/bpfm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpfm_scoreboard
// watches both channels of the frame manager, predicts each result from a
// private copy of the frame table, free queue and lru order, and compares
// ----------------------------------------------------------------------------
module bpfm_scoreboard import bpfm_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [OUT_W-1:0] m_tdata,
    output int               fail_count,
    output int               pending
);
    localparam int NF = FRAMES_DEF;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FRAME_W-1:0]  frame;
        logic                write_back;
        logic [PAGE_W-1:0]   wb_page;
        logic                read_in;
        logic                clear_frame;
        logic                deallocate;
    } pool_result_t;

    logic [PAGE_W-1:0] pg_id [NF];
    logic              pg_valid [NF];
    logic [PIN_W-1:0]  pg_pins [NF];
    logic              pg_dirty [NF];
    int                free_q [$];
    int                lru_q [$];
    pool_result_t      awaited [$];

    function automatic int find_page(logic [PAGE_W-1:0] pid);
        for (int i = 0; i < NF; i++)
            if (pg_valid[i] && pg_id[i] == pid) return i;
        return -1;
    endfunction

    function automatic void lru_drop(int f);
        foreach (lru_q[i])
            if (lru_q[i] == f) begin
                lru_q.delete(i);
                return;
            end
    endfunction

    // victim from free queue first, then least recent unpinned frame
    function automatic int place_page(logic [PAGE_W-1:0] pid, ref pool_result_t r);
        int v;
        int old;
        if (free_q.size() > 0) begin
            v = free_q[0];
            free_q.delete(0);
        end else if (lru_q.size() > 0) begin
            v = lru_q[0];
            lru_q.delete(0);
        end else begin
            r.status = ST_NO_FRAME;
            return -1;
        end
        if (pg_dirty[v]) begin
            r.write_back = 1'b1;
            r.wb_page = pg_id[v];
        end
        pg_valid[v] = 1'b0;
        old = find_page(pid);
        if (old >= 0) pg_valid[old] = 1'b0;
        pg_id[v] = pid;
        pg_valid[v] = 1'b1;
        pg_pins[v] = 1;
        pg_dirty[v] = 1'b0;
        r.frame = v[FRAME_W-1:0];
        return v;
    endfunction

    function automatic pool_result_t serve_request(logic [REQ_W-1:0] req,
                                                  logic [PAGE_W-1:0] pid, logic dflag);
        pool_result_t r;
        int f;
        r = '0;
        f = find_page(pid);
        case (req)
            REQ_FETCH: begin
                if (f >= 0) begin
                    if (pg_pins[f] != PIN_MAX) pg_pins[f]++;
                    lru_drop(f);
                    r.frame = f[FRAME_W-1:0];
                end else if (place_page(pid, r) >= 0) r.read_in = 1'b1;
            end
            REQ_NEW: if (place_page(pid, r) >= 0) r.clear_frame = 1'b1;
            REQ_UNPIN: begin
                if (f < 0) r.status = ST_NOT_FOUND;
                else begin
                    pg_dirty[f] = dflag;
                    r.frame = f[FRAME_W-1:0];
                    if (pg_pins[f] == 0) r.status = ST_NOT_FOUND;
                    else begin
                        pg_pins[f]--;
                        if (pg_pins[f] == 0) begin
                            lru_drop(f);
                            lru_q.insert(lru_q.size(), f);
                        end
                    end
                end
            end
            REQ_FLUSH: begin
                if (f < 0) r.status = ST_NOT_FOUND;
                else begin
                    r.frame = f[FRAME_W-1:0];
                    if (pg_dirty[f]) begin
                        r.write_back = 1'b1;
                        r.wb_page = pid;
                        pg_dirty[f] = 1'b0;
                    end
                end
            end
            REQ_DELETE: begin
                r.deallocate = 1'b1;
                if (f >= 0) begin
                    r.frame = f[FRAME_W-1:0];
                    if (pg_pins[f] != 0) begin
                        r.status = ST_PINNED;
                        r.deallocate = 1'b0;
                    end else begin
                        lru_drop(f);
                        pg_valid[f] = 1'b0;
                        pg_dirty[f] = 1'b0;
                        r.clear_frame = 1'b1;
                        if (free_q.size() < NF) free_q.insert(free_q.size(), f);
                    end
                end
            end
            default: r.status = ST_NOT_FOUND;
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        pool_result_t got;
        pool_result_t want;
        if (!aresetn) begin
            fail_count <= 0;
            pending <= 0;
            awaited.delete();
            free_q.delete();
            lru_q.delete();
            for (int i = 0; i < NF; i++) begin
                pg_id[i] = '0;
                pg_valid[i] = 1'b0;
                pg_pins[i] = '0;
                pg_dirty[i] = 1'b0;
                free_q.insert(free_q.size(), i);
            end
        end else begin
            // predict on each accepted request
            if (s_tvalid && s_tready)
                awaited.insert(awaited.size(),
                               serve_request(s_tdata[2:0], s_tdata[33:3], s_tdata[34]));
            // compare each accepted result with the oldest prediction
            if (m_tvalid && m_tready) begin
                got = {m_tdata[1:0], m_tdata[5:2], m_tdata[6], m_tdata[37:7],
                       m_tdata[38], m_tdata[39], m_tdata[40]};
                if (awaited.size() == 0) begin
                    $error("result item with no request waiting");
                    fail_count <= fail_count + 1;
                end else begin
                    want = awaited[0];
                    awaited.delete(0);
                    if (got != want) fail_count <= fail_count + 1;
                    if (got.status != want.status)
                        $error("status expected %0d got %0d", want.status, got.status);
                    if (got.frame != want.frame)
                        $error("frame expected %0d got %0d", want.frame, got.frame);
                    if (got.write_back != want.write_back)
                        $error("write_back expected %0d got %0d",
                               want.write_back, got.write_back);
                    if (got.wb_page != want.wb_page)
                        $error("write_back_page expected %0h got %0h",
                               want.wb_page, got.wb_page);
                    if (got.read_in != want.read_in)
                        $error("read_in expected %0d got %0d", want.read_in, got.read_in);
                    if (got.clear_frame != want.clear_frame)
                        $error("clear_frame expected %0d got %0d",
                               want.clear_frame, got.clear_frame);
                    if (got.deallocate != want.deallocate)
                        $error("deallocate expected %0d got %0d",
                               want.deallocate, got.deallocate);
                end
            end
            pending <= awaited.size();
        end
    end
endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives page requests into the frame manager: a directed opening over every
// request kind and corner, then random traffic over a small page set with
// random idling on both sides; the scoreboard does all comparison
// ----------------------------------------------------------------------------
module tb;
    import bpfm_pkg::*;

    localparam int WATCHDOG = 20000;

    // request codes outside the defined set
    localparam logic [REQ_W-1:0] REQ_BAD_LO = 3'd5;
    localparam logic [REQ_W-1:0] REQ_BAD_HI = 3'd7;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;
    int               fail_count;
    int               pending;
    int               idle_cycles = 0;
    bit               calm = 1'b0;

    always #4 aclk = ~aclk;

    buffer_pool_frame_manager DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    bpfm_scoreboard scoreboard_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending(pending)
    );

    // result side stall
    always @(posedge aclk)
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 36);

    // watchdog on accepted items
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // one request, with random gaps ahead of it
    task automatic send_req(logic [REQ_W-1:0] req, logic [PAGE_W-1:0] pid, logic dflag);
        while (!calm && $urandom_range(99) < 36) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, dflag, pid, req};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    function automatic logic [PAGE_W-1:0] pick_page();
        case ($urandom_range(9))
            0: return NULL_PAGE;
            1: return PAGE_W'($urandom());
            2: return '0;
            default: return PAGE_W'($urandom_range(23));
        endcase
    endfunction

    initial begin
        logic [PAGE_W-1:0] pid;
        logic [REQ_W-1:0]  req;
        int r;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed opening
        send_req(REQ_FETCH, '0, 1'b0);            // miss, read in
        send_req(REQ_FETCH, '0, 1'b0);            // hit
        send_req(REQ_NEW, NULL_PAGE, 1'b1);
        send_req(REQ_UNPIN, '0, 1'b1);
        send_req(REQ_UNPIN, '0, 1'b1);            // reaches zero pins, dirty
        send_req(REQ_UNPIN, '0, 1'b0);            // already unpinned
        send_req(REQ_UNPIN, 31'd77, 1'b0);        // not resident
        send_req(REQ_FLUSH, NULL_PAGE, 1'b0);     // clean flush
        send_req(REQ_UNPIN, NULL_PAGE, 1'b1);
        send_req(REQ_FLUSH, NULL_PAGE, 1'b0);     // dirty flush
        send_req(REQ_FLUSH, 31'd78, 1'b0);
        send_req(REQ_DELETE, 31'd79, 1'b0);       // not resident
        send_req(REQ_FETCH, 31'h2AAA_AAAA, 1'b0);
        send_req(REQ_DELETE, 31'h2AAA_AAAA, 1'b0); // pinned
        send_req(REQ_NEW, 31'h2AAA_AAAA, 1'b0);   // id already resident
        send_req(REQ_DELETE, NULL_PAGE, 1'b0);
        send_req(REQ_BAD_LO, 31'h5555_5555, 1'b1);
        send_req(REQ_BAD_HI, '0, 1'b0);
        // fill the pool to run out of frames
        for (int i = 0; i < 15; i++) send_req(REQ_NEW, PAGE_W'(100 + i), 1'b0);
        send_req(REQ_FETCH, 31'd200, 1'b0);       // no frame free
        drain_results();

        // release pinned frames so the lru path gets used
        for (int i = 0; i < 15; i++) send_req(REQ_UNPIN, PAGE_W'(100 + i), i[0]);
        send_req(REQ_UNPIN, '0, 1'b1);

        // random traffic; a calm stretch near the middle
        for (int n = 0; n < 140; n++) begin
            calm = (n >= 50 && n < 90);
            r = $urandom_range(99);
            req = (r < 30) ? REQ_FETCH : (r < 45) ? REQ_NEW : (r < 80) ? REQ_UNPIN :
                  (r < 88) ? REQ_FLUSH : (r < 97) ? REQ_DELETE :
                  REQ_W'($urandom_range(REQ_BAD_HI, REQ_BAD_LO));
            pid = pick_page();
            send_req(req, pid, 1'($urandom_range(1)));
            if (n == 100) drain_results();
        end
        // pin saturation on one page
        calm = 1'b1;
        for (int i = 0; i < 260; i++) send_req(REQ_FETCH, 31'd5000, 1'b0);
        send_req(REQ_UNPIN, 31'd5000, 1'b1);
        drain_results();

        repeat (40) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
